// File: rtl/core/qnorm_pkg.sv
// ----------------------------------------------------------------------------
// qnorm_pkg
// shared default component width for the quaternion normalizer
// ----------------------------------------------------------------------------
package qnorm_pkg;
  localparam int unsigned COMP_BITS_DEF = 16;
endpackage

// File: rtl/core/qnorm_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qnorm_sqrt_cell
// one stage of the pipelined square root: settles one result bit
// ----------------------------------------------------------------------------
module qnorm_sqrt_cell #(
  parameter int unsigned CB  = qnorm_pkg::COMP_BITS_DEF,
  parameter int unsigned IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              v_i,
  input  logic              en,
  input  logic [2*CB+1:0]   rem_i,
  input  logic [CB:0]       root_i,
  input  logic [4*CB-1:0]   pay_i,
  input  logic              zero_i,
  output logic              v_o,
  output logic [2*CB+1:0]   rem_o,
  output logic [CB:0]       root_o,
  output logic [4*CB-1:0]   pay_o,
  output logic              zero_o
);
  import qnorm_pkg::*;
  localparam int unsigned RW = 2*CB+2;
  logic [RW-1:0] trial;
  logic [RW-1:0] root_w;
  logic [CB:0]   bitv;
  always_comb begin
    bitv   = (CB+1)'(1) << IDX;
    root_w = RW'(root_i | bitv);
    trial  = (root_w * root_w);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
    if (en) begin
      root_o <= (trial <= rem_i) ? (root_i | bitv) : root_i;
      rem_o  <= rem_i;
      pay_o  <= pay_i;
      zero_o <= zero_i;
    end
  end
endmodule

// File: rtl/core/qnorm_div_cell.sv
// ----------------------------------------------------------------------------
// qnorm_div_cell
// one restoring divider step for all four lanes
// ----------------------------------------------------------------------------
module qnorm_div_cell #(
  parameter int unsigned CB  = qnorm_pkg::COMP_BITS_DEF,
  parameter int unsigned IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              v_i,
  input  logic              en,
  input  logic [CB+1:0]     den_i,
  input  logic [4*(2*CB+2)-1:0] num_i,
  input  logic [4*(CB+2)-1:0]   q_i,
  input  logic [3:0]        neg_i,
  input  logic              zero_i,
  output logic              v_o,
  output logic [CB+1:0]     den_o,
  output logic [4*(2*CB+2)-1:0] num_o,
  output logic [4*(CB+2)-1:0]   q_o,
  output logic [3:0]        neg_o,
  output logic              zero_o
);
  import qnorm_pkg::*;
  localparam int unsigned NW = 2*CB+2;
  localparam int unsigned QW = CB+2;
  logic [4*NW-1:0] num_n;
  logic [4*QW-1:0] q_n;
  logic [NW+QW:0]  sh;
  always_comb begin
    num_n = num_i;
    q_n   = q_i;
    sh    = '0;
    for (int l = 0; l < 4; l++) begin
      sh = (NW+QW+1)'(den_i) << IDX;
      if ((NW+QW+1)'(num_i[l*NW +: NW]) >= sh) begin
        num_n[l*NW +: NW] = num_i[l*NW +: NW] - NW'(sh);
        q_n[l*QW + IDX]   = 1'b1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
    if (en) begin
      den_o  <= den_i;
      num_o  <= num_n;
      q_o    <= q_n;
      neg_o  <= neg_i;
      zero_o <= zero_i;
    end
  end
endmodule

// File: rtl/core/quaternion_normalizer.sv
// ----------------------------------------------------------------------------
// quaternion_normalizer
// scales a quaternion of signed integers to a unit quaternion in signed q1.15
// ----------------------------------------------------------------------------
// one word enters per cycle while the output side does not stall, and passes
// through an input register, a row of CB+1 root cells that settles the length
// floor(sqrt(sum of squares)) one bit per cell, a row of CB+2 divider cells
// that forms the four rounded quotients one bit per cell, and the output
// register; the whole row advances together whenever the output register is
// free or being taken, so a stall on the output side holds every word in
// place. an all-zero quaternion gives zero outputs with zero_length set.
module quaternion_normalizer #(
  parameter int unsigned COMPONENT_BITS = qnorm_pkg::COMP_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [COMPONENT_BITS-1:0] w_in,
  input  logic signed [COMPONENT_BITS-1:0] x_in,
  input  logic signed [COMPONENT_BITS-1:0] y_in,
  input  logic signed [COMPONENT_BITS-1:0] z_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [COMPONENT_BITS-1:0] w_out,
  output logic signed [COMPONENT_BITS-1:0] x_out,
  output logic signed [COMPONENT_BITS-1:0] y_out,
  output logic signed [COMPONENT_BITS-1:0] z_out,
  output logic                             zero_length
);
  import qnorm_pkg::*;
  localparam int unsigned CB = COMPONENT_BITS;
  localparam int unsigned RW = 2*CB+2;   // sum of squares incl carry
  localparam int unsigned NW = 2*CB+2;   // dividend width
  localparam int unsigned QW = CB+2;     // quotient width
  localparam int unsigned NS = CB+1;     // root cells
  localparam logic [QW-1:0] POS_MAX = QW'((64'd1 << (CB-1)) - 1);
  localparam logic [QW-1:0] NEG_MAG = QW'(64'd1 << (CB-1));

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // sign/magnitude split, CB+1-bit magnitude per lane
  logic [CB:0] mag [4];
  logic [3:0]  neg;
  logic [RW-1:0] sum;
  logic signed [CB-1:0] comp [4];
  always_comb begin
    comp[0] = w_in; comp[1] = x_in; comp[2] = y_in; comp[3] = z_in;
    sum = '0;
    for (int l = 0; l < 4; l++) begin
      neg[l] = comp[l][CB-1];
      mag[l] = neg[l] ? (CB+1)'(-$signed({comp[l][CB-1], comp[l]}))
                      : (CB+1)'({1'b0, comp[l]});
      sum = sum + RW'(mag[l]) * RW'(mag[l]);
    end
  end

  // input register
  logic              v0;
  logic [RW-1:0]     sum0;
  logic [4*CB-1:0]   pay0;
  logic              zero0;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
    if (en) begin
      sum0  <= sum;
      zero0 <= (sum == '0);
      for (int l = 0; l < 4; l++) begin
        pay0[l*CB +: CB] <= {neg[l], mag[l][CB-2:0]} ^ {1'b0, {(CB-1){1'b0}}};
      end
    end
  end
  // note: lane carries sign in msb and low magnitude bits; the magnitude msb
  // is recovered as (neg && low bits zero) for the most negative value

  // root chain, msb first
  logic              sv [NS+1];
  logic [RW-1:0]     sr [NS+1];
  logic [CB:0]       sq [NS+1];
  logic [4*CB-1:0]   sp [NS+1];
  logic              sz [NS+1];
  assign sv[0] = v0;
  assign sr[0] = sum0;
  assign sq[0] = '0;
  assign sp[0] = pay0;
  assign sz[0] = zero0;
  for (genvar i = 0; i < NS; i++) begin : g_root
    qnorm_sqrt_cell #(.CB(CB), .IDX(NS-1-i)) u_cell (
      .clk, .rst, .en,
      .v_i(sv[i]), .rem_i(sr[i]), .root_i(sq[i]), .pay_i(sp[i]), .zero_i(sz[i]),
      .v_o(sv[i+1]), .rem_o(sr[i+1]), .root_o(sq[i+1]), .pay_o(sp[i+1]),
      .zero_o(sz[i+1])
    );
  end

  // divider setup: q = (mag*2^CB + len) / (2*len)
  logic [CB+1:0]   den;
  logic [4*NW-1:0] num;
  logic [3:0]      dneg;
  logic [CB:0]     m;
  logic [CB:0]     len;
  always_comb begin
    len = sz[NS] ? (CB+1)'(1) : sq[NS];
    den = {len, 1'b0};
    for (int l = 0; l < 4; l++) begin
      dneg[l] = sp[NS][l*CB + CB-1];
      m = {1'b0, dneg[l] && (sp[NS][l*CB +: CB-1] == '0), sp[NS][l*CB +: CB-1]};
      num[l*NW +: NW] = (NW'(m) << CB) + NW'(len);
    end
  end

  logic              dv [QW+1];
  logic [CB+1:0]     dd [QW+1];
  logic [4*NW-1:0]   dn [QW+1];
  logic [4*QW-1:0]   dq [QW+1];
  logic [3:0]        dg [QW+1];
  logic              dz [QW+1];
  assign dv[0] = sv[NS];
  assign dd[0] = den;
  assign dn[0] = num;
  assign dq[0] = '0;
  assign dg[0] = dneg;
  assign dz[0] = sz[NS];
  for (genvar i = 0; i < QW; i++) begin : g_div
    qnorm_div_cell #(.CB(CB), .IDX(QW-1-i)) u_cell (
      .clk, .rst, .en,
      .v_i(dv[i]), .den_i(dd[i]), .num_i(dn[i]), .q_i(dq[i]), .neg_i(dg[i]),
      .zero_i(dz[i]),
      .v_o(dv[i+1]), .den_o(dd[i+1]), .num_o(dn[i+1]), .q_o(dq[i+1]),
      .neg_o(dg[i+1]), .zero_o(dz[i+1])
    );
  end

  // saturate, apply sign, output register
  logic [CB-1:0] res [4];
  logic [QW-1:0] q;
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      q = dq[QW][l*QW +: QW];
      if (dz[QW]) begin
        res[l] = '0;
      end else if (!dg[QW][l]) begin
        res[l] = (q > POS_MAX) ? CB'(POS_MAX) : CB'(q);
      end else begin
        res[l] = CB'(-((q > NEG_MAG) ? NEG_MAG : q));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[QW];
    end
    if (en) begin
      w_out       <= res[0];
      x_out       <= res[1];
      y_out       <= res[2];
      z_out       <= res[3];
      zero_length <= dz[QW];
    end
  end
endmodule

// File: test/quaternion_normalizer_test.sv
// ----------------------------------------------------------------------------
// quaternion_normalizer_test
// drives quaternion words through the normalizer with random idling on both
// sides and checks every normalized word against an integer predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
  logic signed [15:0] w;
  logic signed [15:0] x;
  logic signed [15:0] y;
  logic signed [15:0] z;
  logic               zl;
} unit_quat_t;

class unit_quat_board;
  unit_quat_t pending[$];
  int         mismatches;

  // floor(sqrt(s)) by the bit-serial method
  static function longint unsigned int_root(longint unsigned s);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // component * 2^15 / len, nearest with ties away from zero, saturated
  static function logic [15:0] scale_comp(logic signed [15:0] c, longint unsigned len);
    longint unsigned mag;
    longint unsigned q;
    mag = (c < 0) ? longint'(-int'(c)) : longint'(c);
    q = ((mag << 16) + len) / (len << 1);
    if (c >= 0) return (q > 32767) ? 16'h7fff : q[15:0];
    if (q > 32768) q = 32768;
    return 16'(-q);
  endfunction

  function void note_quat(logic signed [15:0] w, logic signed [15:0] x,
                          logic signed [15:0] y, logic signed [15:0] z);
    longint unsigned sum;
    longint unsigned len;
    unit_quat_t e;
    sum = longint'(int'(w) * int'(w)) + longint'(int'(x) * int'(x))
        + longint'(int'(y) * int'(y)) + longint'(int'(z) * int'(z));
    if (sum == 0) begin
      e = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1};
    end else begin
      len = int_root(sum);
      e.w = scale_comp(w, len);
      e.x = scale_comp(x, len);
      e.y = scale_comp(y, len);
      e.z = scale_comp(z, len);
      e.zl = 1'b0;
    end
    pending.push_back(e);
  endfunction

  function void check_quat(unit_quat_t got);
    unit_quat_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected word %h", got);
      return;
    end
    e = pending.pop_front();
    if (got !== e) begin
      mismatches++;
      if (mismatches <= 10) begin
        $write("mismatch: expected w %0d x %0d y %0d z %0d zl %0b,",
               e.w, e.x, e.y, e.z, e.zl);
        $display(" got w %0d x %0d y %0d z %0d zl %0b",
                 got.w, got.x, got.y, got.z, got.zl);
      end
    end
  endfunction
endclass

module quaternion_normalizer_test;
  localparam int RANDOM_WORDS = 950;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] w_in = '0, x_in = '0, y_in = '0, z_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] w_out, x_out, y_out, z_out;
  logic zero_length;

  unit_quat_board board = new();
  bit   sending_done = 0;
  bit   calm = 0;   // set near the end: no more idling

  always #1 clk = ~clk;

  quaternion_normalizer u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .w_in(w_in), .x_in(x_in), .y_in(y_in), .z_in(z_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .w_out(w_out), .x_out(x_out), .y_out(y_out), .z_out(z_out),
    .zero_length(zero_length)
  );

  // note inputs and check outputs on the rising edge
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) board.note_quat(w_in, x_in, y_in, z_in);
    if (!rst && out_valid && out_ready)
      board.check_quat('{w_out, x_out, y_out, z_out, zero_length});
  end

  // present one word from a falling edge and hold it until taken
  task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    w_in <= w; x_in <= x; y_in <= y; z_in <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // random component: often small scales, sometimes extremes
  function automatic logic signed [15:0] pick_comp();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 3)) - 16'sd1;
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return 16'($urandom_range(0, 511)) - 16'sd256;
      default: return 16'($urandom());
    endcase
  endfunction

  // output side: ready in random bursts, steady at the end
  initial begin
    int n;
    @(negedge clk);
    while (1) begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 19);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 19);
      end
      repeat (n) @(negedge clk);
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: zero length, extremes, saturation above and below one
    send_quat(0, 0, 0, 0);
    send_quat(16'sh7fff, 0, 0, 0);
    send_quat(16'sh8000, 0, 0, 0);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_quat(1, 1, 0, 0);
    send_quat(-1, -1, 0, 0);
    send_quat(1, -1, 1, -1);
    send_quat(0, 1, 0, 0);
    send_quat(0, 0, -1, 0);
    send_quat(0, 0, 0, 16'sh8000);
    send_quat(3, 4, 0, 0);
    send_quat(-1, 0, 0, 0);
    send_quat(0, 0, 0, 0);
    send_quat(16'sh5555, 16'shaaaa, 16'sh00ff, 16'shff00);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - 100) calm = 1;
      send_quat(pick_comp(), pick_comp(), pick_comp(), pick_comp());
    end
    in_valid <= 1'b0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.mismatches == 0) $display("quaternion_normalizer_test: clean");
    else $display("quaternion_normalizer_test: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("quaternion_normalizer_test: errors");
    $finish;
  end
endmodule
